// File: hdl/arpc_pkg.sv
// ============================================================================
// arpc_pkg
// Types, sizes and codes shared by the ARP cache lookup and learn unit.
// ============================================================================
package arpc_pkg;

  localparam int ENTRIES = 1024;
  localparam int PORTS   = 2;

  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int CNT_W     = $clog2(ENTRIES + 1);
  localparam int PORT_W    = (PORTS > 1) ? $clog2(PORTS) : 1;
  localparam int ADDR_W    = PORT_W + IDX_W;
  localparam int MEM_DEPTH = 2 ** ADDR_W;

  localparam int PORT_IN_W     = 1;
  localparam int IP_W          = 32;
  localparam int MAC_W         = 48;
  localparam int TIME_W        = 32;
  localparam int TIMEOUT_W     = 16;
  localparam int ENTRY_INDEX_W = 10;

  localparam logic [1:0] ST_FREE     = 2'd0;
  localparam logic [1:0] ST_PENDING  = 2'd1;
  localparam logic [1:0] ST_RESOLVED = 2'd2;

  localparam logic [TIMEOUT_W-1:0] RESOLVED_TIMEOUT_RESET = 16'd60;
  localparam logic [TIMEOUT_W-1:0] PENDING_TIMEOUT_RESET  = 16'd1;

  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = PADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_RESOLVED_TIMEOUT = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_PENDING_TIMEOUT  = 1'd1;

  typedef struct packed {
    logic [PORT_IN_W-1:0] port;
    logic [IP_W-1:0]      ip_addr;
    logic                 has_mac;
    logic [MAC_W-1:0]     mac_in;
    logic [TIME_W-1:0]    now_seconds;
  } in_item_t;

  typedef struct packed {
    logic [ENTRY_INDEX_W-1:0] entry_index;
    logic                     resolved;
    logic [MAC_W-1:0]         mac_out;
    logic                     send_request;
    logic                     added;
    logic                     table_full;
  } out_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [IP_W-1:0]   ip;
    logic [MAC_W-1:0]  mac;
    logic [TIME_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic [TIMEOUT_W-1:0] resolved_timeout;
    logic [TIMEOUT_W-1:0] pending_timeout;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic miss;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic hit;
    logic scan_end;
    logic out_free;
  } dp_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_MISS,
    S_RESULT
  } state_t;

  // Port numbers beyond the last table fold onto the last table.
  function automatic logic [PORT_W-1:0] port_select(input logic [PORT_IN_W-1:0] p);
    if (int'(p) >= PORTS) begin
      return PORT_W'(PORTS - 1);
    end
    return PORT_W'(p);
  endfunction

endpackage

// File: hdl/arpc_regs.sv
// ============================================================================
// arpc_regs
// APB register file holding the resolved and pending timeouts.
// ============================================================================
module arpc_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [arpc_pkg::PADDR_W-1:0]  paddr,
  input  logic [arpc_pkg::PDATA_W-1:0]  pwdata,
  output logic [arpc_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output arpc_pkg::cfg_t                cfg
);
  import arpc_pkg::*;

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.resolved_timeout <= RESOLVED_TIMEOUT_RESET;
      cfg.pending_timeout  <= PENDING_TIMEOUT_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_RESOLVED_TIMEOUT: cfg.resolved_timeout <= pwdata[TIMEOUT_W-1:0];
        REG_PENDING_TIMEOUT:  cfg.pending_timeout  <= pwdata[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_RESOLVED_TIMEOUT: prdata = PDATA_W'(cfg.resolved_timeout);
      REG_PENDING_TIMEOUT:  prdata = PDATA_W'(cfg.pending_timeout);
      default:              prdata = '0;
    endcase
  end

endmodule

// File: hdl/arpc_ctrl.sv
// ============================================================================
// arpc_ctrl
// Sequencer for one lookup: accept, scan the table, insert on a miss,
// then hand the result to the output register.
// ============================================================================
module arpc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 lookup_valid,
  output logic                 lookup_ready,
  input  arpc_pkg::dp_status_t st,
  output arpc_pkg::dp_cmd_t    cmd
);
  import arpc_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (lookup_valid) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (st.hit) begin
          state_next = S_RESULT;
        end else if (st.scan_end) begin
          state_next = S_MISS;
        end
      end
      S_MISS: begin
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (st.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd          = '0;
    lookup_ready = 1'b0;
    case (state)
      S_IDLE: begin
        lookup_ready = 1'b1;
        cmd.start    = lookup_valid;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
      end
      S_MISS: begin
        cmd.miss = 1'b1;
      end
      S_RESULT: begin
        cmd.load_out = st.out_free;
      end
      default: ;
    endcase
  end

endmodule

// File: hdl/arpc_datapath.sv
// ============================================================================
// arpc_datapath
// Entry memory, fill counts, the per-entry aging and match logic, and the
// result and output registers.
// ============================================================================
module arpc_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  arpc_pkg::dp_cmd_t    cmd,
  output arpc_pkg::dp_status_t st,
  input  arpc_pkg::cfg_t       cfg,
  input  arpc_pkg::in_item_t   lookup,
  output arpc_pkg::out_item_t  result,
  output logic                 result_valid,
  input  logic                 result_ready
);
  import arpc_pkg::*;

  // Lookup held for the whole transaction.
  logic [PORT_W-1:0] port_q;
  logic [IP_W-1:0]   ip_q;
  logic              has_mac_q;
  logic [MAC_W-1:0]  mac_q;
  logic [TIME_W-1:0] now_q;
  logic [CNT_W-1:0]  count_q;

  logic [CNT_W-1:0]  used_count [PORTS];

  logic [CNT_W-1:0]  rd_idx;
  logic [IDX_W-1:0]  ev_idx;
  logic              rvalid;
  logic              have_free;
  logic [IDX_W-1:0]  free_idx;

  entry_t            mem [MEM_DEPTH];
  entry_t            rdata;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  entry_t            wr_data;

  logic              ev;
  logic              e_res;
  logic [TIME_W-1:0] age;
  logic [TIME_W-1:0] limit;
  logic              expired;
  logic              ip_match;
  logic              ev_hit;
  logic              ev_take;
  logic              ev_wr;
  entry_t            ev_wdata;
  logic              hit_res;
  logic [MAC_W-1:0]  hit_mac;

  logic              miss_full;
  logic [IDX_W-1:0]  miss_idx;
  entry_t            ins_data;
  out_item_t         full_res;

  out_item_t         res;
  out_item_t         out_q;
  logic              out_valid;

  // One entry read per cycle; the entry read last cycle is judged this cycle.
  assign rd_en   = cmd.scan && (rd_idx < count_q);
  assign rd_addr = {port_q, rd_idx[IDX_W-1:0]};

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata <= mem[rd_addr];
  end

  always_comb begin
    ev       = cmd.scan && rvalid;
    e_res    = rdata.status == ST_RESOLVED;
    age      = now_q - rdata.stamp;
    limit    = e_res ? TIME_W'(cfg.resolved_timeout) : TIME_W'(cfg.pending_timeout);
    expired  = age > limit;
    ip_match = rdata.ip == ip_q;

    ev_hit   = 1'b0;
    ev_take  = 1'b0;
    ev_wr    = 1'b0;
    ev_wdata = rdata;
    hit_res  = 1'b0;
    hit_mac  = '0;

    if (ev) begin
      if (rdata.status == ST_FREE) begin
        ev_take = 1'b1;
      end else if (ip_match && has_mac_q) begin
        // Learning on a match: the time is refreshed only for an entry that
        // was already resolved.
        ev_wr           = 1'b1;
        ev_wdata.status = ST_RESOLVED;
        ev_wdata.mac    = mac_q;
        if (e_res) ev_wdata.stamp = now_q;
        ev_hit  = 1'b1;
        hit_res = 1'b1;
        hit_mac = mac_q;
      end else if (ip_match && e_res) begin
        ev_wr          = 1'b1;
        ev_wdata.stamp = now_q;
        ev_hit         = 1'b1;
        hit_res        = 1'b1;
        hit_mac        = rdata.mac;
      end else if (ip_match && !expired) begin
        ev_hit = 1'b1;
      end else if (ip_match || expired) begin
        ev_wr           = 1'b1;
        ev_wdata.status = ST_FREE;
        ev_take         = 1'b1;
      end
    end
  end

  always_comb begin
    miss_full       = !have_free && (count_q >= CNT_W'(ENTRIES));
    miss_idx        = have_free ? free_idx : count_q[IDX_W-1:0];
    ins_data.status = has_mac_q ? ST_RESOLVED : ST_PENDING;
    ins_data.ip     = ip_q;
    ins_data.mac    = has_mac_q ? mac_q : '0;
    ins_data.stamp  = now_q;

    full_res            = '0;
    full_res.table_full = 1'b1;

    wr_en   = ev_wr || (cmd.miss && !miss_full);
    wr_addr = cmd.miss ? {port_q, miss_idx} : {port_q, ev_idx};
    wr_data = cmd.miss ? ins_data : ev_wdata;
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      port_q    <= port_select(lookup.port);
      ip_q      <= lookup.ip_addr;
      has_mac_q <= lookup.has_mac;
      mac_q     <= lookup.mac_in;
      now_q     <= lookup.now_seconds;
      count_q   <= used_count[port_select(lookup.port)];
    end
    if (rd_en) ev_idx <= rd_idx[IDX_W-1:0];
    if (ev_take && !have_free) free_idx <= ev_idx;

    if (ev_hit) begin
      res.entry_index  <= ENTRY_INDEX_W'(ev_idx);
      res.resolved     <= hit_res;
      res.mac_out      <= hit_mac;
      res.send_request <= !hit_res;
      res.added        <= 1'b0;
      res.table_full   <= 1'b0;
    end else if (cmd.miss) begin
      if (miss_full) begin
        res <= full_res;
      end else begin
        res.entry_index  <= ENTRY_INDEX_W'(miss_idx);
        res.resolved     <= has_mac_q;
        res.mac_out      <= ins_data.mac;
        res.send_request <= !has_mac_q;
        res.added        <= 1'b1;
        res.table_full   <= 1'b0;
      end
    end

    if (cmd.load_out) out_q <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx    <= '0;
      rvalid    <= 1'b0;
      have_free <= 1'b0;
      out_valid <= 1'b0;
      for (int p = 0; p < PORTS; p++) begin
        used_count[p] <= '0;
      end
    end else begin
      if (cmd.start) begin
        rd_idx    <= '0;
        rvalid    <= 1'b0;
        have_free <= 1'b0;
      end else begin
        if (rd_en) rd_idx <= rd_idx + 1'b1;
        rvalid <= rd_en;
        if (ev_take) have_free <= 1'b1;
      end
      // A slot past the fill mark is taken only when no freed slot exists.
      if (cmd.miss && !miss_full && !have_free) begin
        used_count[port_q] <= count_q + 1'b1;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (result_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign st.hit      = ev_hit;
  assign st.scan_end = cmd.scan && !rvalid && !(rd_idx < count_q);
  assign st.out_free = !out_valid || result_ready;

  assign result       = out_q;
  assign result_valid = out_valid;

endmodule

// File: hdl/arp_cache_lookup_learn_unit.sv
// ============================================================================
// arp_cache_lookup_learn_unit
// Per-port IPv4-to-MAC cache with aging, lookup, refresh and learning.
// ============================================================================
//
//   channel   handshake                      payload
//   --------  -----------------------------  -------------------------------
//   lookup    lookup_valid / lookup_ready    in_item_t (port, ip, mac, time)
//   result    result_valid / result_ready    out_item_t (index, flags, mac)
//   config    psel, penable, pwrite, pready  paddr, pwdata, prdata (timeouts)
//
// A lookup keeps the unit busy from acceptance until it is ready again for a
// span that grows with used_count and is shorter when a match ends the scan
// early; the single read port of the entry memory sets this, one entry a
// cycle.
// Reset needs no clearing pass: slots at or past a table's fill count are
// never read, so only the fill counts are cleared.
// A finished result waits in the output register while the next transaction
// is accepted and scanned; a transaction stalls, after its scan, only when its
// result finds that register still full.
module arp_cache_lookup_learn_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          lookup_valid,
  output logic                          lookup_ready,
  input  arpc_pkg::in_item_t            lookup,
  output logic                          result_valid,
  input  logic                          result_ready,
  output arpc_pkg::out_item_t           result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [arpc_pkg::PADDR_W-1:0]  paddr,
  input  logic [arpc_pkg::PDATA_W-1:0]  pwdata,
  output logic [arpc_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import arpc_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t st;

  arpc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  arpc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .lookup_valid (lookup_valid),
    .lookup_ready (lookup_ready),
    .st           (st),
    .cmd          (cmd)
  );

  arpc_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .cfg          (cfg),
    .lookup       (lookup),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (result_ready)
  );

  // A full table reports nothing but the full flag.
  a_full_clean : assert property (@(posedge clk) disable iff (rst)
    result_valid && result.table_full |->
      !result.added && !result.resolved && !result.send_request &&
      result.entry_index == '0 && result.mac_out == '0)
    else $error("full result carries entry data");

  // A pending entry never shows a hardware address.
  a_pending_no_mac : assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.resolved |-> result.mac_out == '0)
    else $error("unresolved result with nonzero mac");

  // Outside the full case exactly one of resolved and send_request is set.
  a_res_xor_req : assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.table_full |-> result.resolved != result.send_request)
    else $error("resolved and send_request disagree");

  // Only one transaction is in flight: acceptance closes the input.
  a_one_in_flight : assert property (@(posedge clk) disable iff (rst)
    lookup_valid && lookup_ready |=> !lookup_ready)
    else $error("second lookup accepted during a scan");

endmodule

// File: tb/sv/tb_arp_cache_lookup_learn_unit.sv
// ============================================================================
// tb_arp_cache_lookup_learn_unit
// Self-checking bench for the ARP cache: directed aging and learning cases,
// then random traffic over a small address pool under several timeout
// settings and idling patterns. Expected results come from a behavioral copy
// of the cache that is updated on every accepted lookup transaction.
// ============================================================================
module tb_arp_cache_lookup_learn_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import arpc_pkg::*;

  localparam int POOL_SIZE   = 12;
  localparam int HOLD_CYCLES = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic      lookup_valid = 1'b0;
  logic      lookup_ready;
  in_item_t  lookup = '0;
  logic      result_valid;
  logic      result_ready = 1'b0;
  out_item_t result;

  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  // Behavioral copy of both tables and of the timeout registers.
  bit [1:0]           cache_status [PORTS*ENTRIES];
  bit [IP_W-1:0]      cache_ip     [PORTS*ENTRIES];
  bit [MAC_W-1:0]     cache_mac    [PORTS*ENTRIES];
  bit [TIME_W-1:0]    cache_stamp  [PORTS*ENTRIES];
  int unsigned        fill_count   [PORTS];
  logic [TIMEOUT_W-1:0] resolved_limit = RESOLVED_TIMEOUT_RESET;
  logic [TIMEOUT_W-1:0] pending_limit  = PENDING_TIMEOUT_RESET;

  in_item_t  lookup_backlog[$];
  out_item_t expected_results[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_request = 1'b0;
  int unsigned hold_left = 0;
  int unsigned fail_count = 0;

  logic [IP_W-1:0]   ip_pool [POOL_SIZE];
  logic [TIME_W-1:0] sim_now = '0;

  arp_cache_lookup_learn_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .lookup_valid (lookup_valid),
    .lookup_ready (lookup_ready),
    .lookup       (lookup),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic bit entry_stale(input int unsigned slot, input logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] age;
    age = now - cache_stamp[slot];
    if (cache_status[slot] == ST_RESOLVED) begin
      return age > resolved_limit;
    end
    return age > pending_limit;
  endfunction

  function automatic out_item_t slot_result(input int unsigned idx, input int unsigned slot,
                                            input logic added);
    out_item_t r;
    r = '0;
    r.entry_index  = ENTRY_INDEX_W'(idx);
    r.resolved     = (cache_status[slot] == ST_RESOLVED);
    r.mac_out      = r.resolved ? cache_mac[slot] : '0;
    r.send_request = !r.resolved;
    r.added        = added;
    return r;
  endfunction

  // One scan of the selected table: aging, first free slot, refresh or learn.
  function automatic out_item_t resolve_lookup(input in_item_t item);
    int unsigned tbl, base, cnt, slot, free_idx;
    bit          have_free;
    out_item_t   full_result;
    tbl = item.port;
    if (tbl >= PORTS) begin
      tbl = PORTS - 1;
    end
    base = tbl * ENTRIES;
    cnt = fill_count[tbl];
    if (cnt > ENTRIES) begin
      cnt = ENTRIES;
    end
    have_free = 1'b0;
    free_idx = 0;
    for (int unsigned i = 0; i < cnt; i++) begin
      slot = base + i;
      if (cache_status[slot] == ST_FREE) begin
        if (!have_free) begin
          have_free = 1'b1;
          free_idx = i;
        end
        continue;
      end
      if (cache_ip[slot] == item.ip_addr) begin
        if (cache_status[slot] == ST_RESOLVED) begin
          cache_stamp[slot] = item.now_seconds;
        end
        // A learned MAC ends the scan; a pending entry keeps its old stamp.
        if (item.has_mac) begin
          cache_mac[slot] = item.mac_in;
          cache_status[slot] = ST_RESOLVED;
          return slot_result(i, slot, 1'b0);
        end
        if (!entry_stale(slot, item.now_seconds)) begin
          return slot_result(i, slot, 1'b0);
        end
      end else if (!entry_stale(slot, item.now_seconds)) begin
        continue;
      end
      cache_status[slot] = ST_FREE;
      if (!have_free) begin
        have_free = 1'b1;
        free_idx = i;
      end
    end
    if (!have_free) begin
      if (cnt >= ENTRIES) begin
        full_result = '0;
        full_result.table_full = 1'b1;
        return full_result;
      end
      free_idx = cnt;
      fill_count[tbl] = cnt + 1;
    end
    slot = base + free_idx;
    cache_ip[slot]     = item.ip_addr;
    cache_status[slot] = item.has_mac ? ST_RESOLVED : ST_PENDING;
    cache_mac[slot]    = item.has_mac ? item.mac_in : '0;
    cache_stamp[slot]  = item.now_seconds;
    return slot_result(free_idx, slot, 1'b1);
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // Lookup driver: holds each transaction until accepted, predicts on acceptance.
  always @(posedge clk) begin : lookup_driver
    bit       offer;
    in_item_t next_item;
    if (rst) begin
      lookup_valid <= 1'b0;
    end else begin
      offer = lookup_valid;
      if (lookup_valid && lookup_ready) begin
        expected_results.push_back(resolve_lookup(lookup));
        offer = 1'b0;
      end
      if (!offer && lookup_backlog.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        next_item = lookup_backlog.pop_front();
        lookup <= next_item;
        offer = 1'b1;
      end
      lookup_valid <= offer;
    end
  end

  always @(posedge clk) begin : result_monitor
    out_item_t want;
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, result);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("entry_index", want.entry_index, result.entry_index);
          check_field("resolved", want.resolved, result.resolved);
          check_field("mac_out", want.mac_out, result.mac_out);
          check_field("send_request", want.send_request, result.send_request);
          check_field("added", want.added, result.added);
          check_field("table_full", want.table_full, result.table_full);
        end
      end
      result_ready <= (hold_left == 0) && ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  // Long receiver hold-off, counted here so the sender keeps offering meanwhile.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_request && hold_left == 0) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  task automatic apb_transfer(input logic is_write, input logic [PADDR_W-1:0] addr,
                              input logic [PDATA_W-1:0] wdata,
                              output logic [PDATA_W-1:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_timeout(input logic [REG_IDX_W-1:0] which,
                             input logic [TIMEOUT_W-1:0] value);
    logic [PDATA_W-1:0] readback;
    apb_transfer(1'b1, PADDR_W'({which, 2'b00}), PDATA_W'(value), readback);
    if (which == REG_RESOLVED_TIMEOUT) begin
      resolved_limit = value;
    end else begin
      pending_limit = value;
    end
    apb_transfer(1'b0, PADDR_W'({which, 2'b00}), '0, readback);
    if (readback !== PDATA_W'(value)) begin
      $display("%0t: register %0d readback mismatch, expected 0x%0h, actual 0x%0h",
               $time, which, value, readback);
      fail_count++;
    end
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct  <= send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  task automatic queue_lookup(input logic [PORT_IN_W-1:0] tbl, input logic [IP_W-1:0] ip,
                              input logic has_mac, input logic [MAC_W-1:0] mac,
                              input logic [TIME_W-1:0] now);
    in_item_t item;
    item.port        = tbl;
    item.ip_addr     = ip;
    item.has_mac     = has_mac;
    item.mac_in      = mac;
    item.now_seconds = now;
    lookup_backlog.push_back(item);
  endtask

  // Mostly addresses from a small pool so entries get refreshed, learned and
  // aged; a tenth are fresh addresses. Time creeps, sometimes jumps anywhere.
  task automatic queue_random(input int count);
    int unsigned pick;
    logic [IP_W-1:0] ip;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99, 0);
      if (pick < 5) begin
        sim_now = $urandom();
      end else if (pick < 15) begin
        sim_now += $urandom_range(200, 0);
      end else begin
        sim_now += $urandom_range(2, 0);
      end
      if ($urandom_range(9, 0) == 0) begin
        ip = $urandom();
      end else begin
        ip = ip_pool[$urandom_range(POOL_SIZE - 1, 0)];
      end
      queue_lookup(PORT_IN_W'($urandom_range(1, 0)), ip, $urandom_range(99, 0) < 45,
                   MAC_W'({$urandom(), $urandom()}), sim_now);
    end
  endtask

  task automatic wait_until_idle();
    do @(posedge clk);
    while (lookup_backlog.size() != 0 || lookup_valid || expected_results.size() != 0 ||
           !lookup_ready);
  endtask

  initial begin
    #100_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    ip_pool[0] = '0;
    ip_pool[1] = '1;
    for (int k = 2; k < POOL_SIZE; k++) begin
      ip_pool[k] = $urandom();
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed cases under the reset timeouts.
    queue_lookup(1'b0, 32'h0000_0000, 1'b0, '0, 32'd100);
    queue_lookup(1'b0, 32'h0000_0000, 1'b0, '0, 32'd100);
    queue_lookup(1'b0, 32'h0000_0000, 1'b1, 48'hFFFF_FFFF_FFFF, 32'd101);
    queue_lookup(1'b1, 32'hFFFF_FFFF, 1'b1, 48'h0, 32'd0);
    queue_lookup(1'b0, 32'hC0A8_0001, 1'b0, '0, 32'd101);
    // Pending entry hit after it has expired: freed and taken again.
    queue_lookup(1'b0, 32'hC0A8_0001, 1'b0, '0, 32'd103);
    queue_lookup(1'b0, 32'h0000_0000, 1'b0, '0, 32'd161);
    queue_lookup(1'b0, 32'hC0A8_0002, 1'b0, '0, 32'd161);
    queue_lookup(1'b0, 32'h0A00_0001, 1'b1, 48'h0123_4567_89AB, 32'd161);
    queue_lookup(1'b0, 32'h0A00_0002, 1'b0, '0, 32'd300);
    queue_lookup(1'b0, 32'h0A00_0003, 1'b0, '0, 32'd300);
    queue_lookup(1'b0, 32'h0A00_0004, 1'b0, '0, 32'd300);
    // A learned MAC stops the scan, so the stale entries behind it survive.
    queue_lookup(1'b0, 32'h0A00_0002, 1'b1, 48'hA5A5_5A5A_0F0F, 32'd400);
    queue_lookup(1'b0, 32'h0A00_0004, 1'b0, '0, 32'd400);
    // Age computed across the wrap of the seconds counter.
    queue_lookup(1'b1, 32'h0102_0304, 1'b1, 48'h8000_0000_0001, 32'hFFFF_FFFE);
    queue_lookup(1'b1, 32'h0102_0304, 1'b0, '0, 32'h0000_0010);
    queue_lookup(1'b1, 32'h0102_0304, 1'b1, 48'h7FFF_FFFF_FFFE, 32'h0000_0020);
    wait_until_idle();

    set_timeout(REG_RESOLVED_TIMEOUT, 16'd5);
    set_timeout(REG_PENDING_TIMEOUT, 16'd2);
    set_idling(0, 0);
    queue_random(135);
    @(posedge clk);
    hold_request <= 1'b1;
    @(posedge clk);
    hold_request <= 1'b0;
    wait_until_idle();

    set_timeout(REG_RESOLVED_TIMEOUT, 16'hFFFF);
    set_timeout(REG_PENDING_TIMEOUT, 16'hFFFF);
    set_idling(49, 0);
    queue_random(135);
    wait_until_idle();

    set_timeout(REG_RESOLVED_TIMEOUT, 16'd0);
    set_timeout(REG_PENDING_TIMEOUT, 16'd0);
    set_idling(0, 49);
    queue_random(135);
    wait_until_idle();

    set_timeout(REG_RESOLVED_TIMEOUT, TIMEOUT_W'($urandom_range(100, 1)));
    set_timeout(REG_PENDING_TIMEOUT, TIMEOUT_W'($urandom_range(10, 1)));
    set_idling(6, 6);
    sim_now = 32'hFFFF_FF00;
    queue_random(135);
    wait_until_idle();

    repeat (1100) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/arpc_pkg.sv
hdl/arpc_regs.sv
hdl/arpc_ctrl.sv
hdl/arpc_datapath.sv
hdl/arp_cache_lookup_learn_unit.sv
tb/sv/tb_arp_cache_lookup_learn_unit.sv
